[sv/assert_macros.svh]
// Assertion macros used by the top-level RTL file, which checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/tpha_pkg.sv]
// Types, codes and sizes shared by the two-pool handle allocator.
package tpha_pkg;

	localparam int POOL_CAPACITY = 256;
	localparam int SLOT_W        = $clog2(POOL_CAPACITY);
	localparam int COUNT_W       = SLOT_W + 1;
	localparam int FIELD_SLOT_W  = 8;
	localparam int MEM_DEPTH     = 2 * POOL_CAPACITY;

	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	localparam logic [1:0] STS_OK      = 2'd0;
	localparam logic [1:0] STS_INVALID = 2'd1;
	localparam logic [1:0] STS_REMOVED = 2'd2;
	localparam logic [1:0] STS_FULL    = 2'd3;

	typedef struct packed {
		logic [1:0]              cmd;
		logic                    pool;
		logic [FIELD_SLOT_W-1:0] slot;
	} req_t;

	typedef struct packed {
		logic                    out_pool;
		logic [FIELD_SLOT_W-1:0] out_slot;
		logic [1:0]              status;
	} rsp_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic exec;
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic known;
	} dp_sts_t;

endpackage

[sv/tpha_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tpha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[sv/tpha_ctrl.sv]
// Controller state machine: accept, execute, result strobe.
module tpha_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  tpha_pkg::dp_sts_t  sts,
	output tpha_pkg::ctrl_cmd_t cmd,
	output logic               busy,
	output logic               done
);

	tpha_pkg::state_t state_q, state_d;
	logic             done_q, done_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tpha_pkg::ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		busy     = 1'b0;
		done_d   = 1'b0;
		case (state_q)
			tpha_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = tpha_pkg::ST_EXEC;
				end
			end
			tpha_pkg::ST_EXEC: begin
				busy     = 1'b1;
				cmd.exec = 1'b1;
				done_d   = sts.known;
				state_d  = tpha_pkg::ST_IDLE;
			end
			default: begin
				state_d = tpha_pkg::ST_IDLE;
			end
		endcase
	end

	assign done = done_q;

endmodule

[sv/tpha_dpath.sv]
// Datapath: pool counters, live-flag and free-stack RAMs, result register.
module tpha_dpath (
	input  logic                clk,
	input  logic                arst_n,
	input  tpha_pkg::ctrl_cmd_t cmd,
	input  tpha_pkg::req_t      req,
	output tpha_pkg::dp_sts_t   sts,
	output tpha_pkg::rsp_t      rsp
);

	localparam int SW = tpha_pkg::SLOT_W;
	localparam int CW = tpha_pkg::COUNT_W;
	localparam int AW = $clog2(tpha_pkg::MEM_DEPTH);
	localparam logic [CW-1:0] CAP = CW'(tpha_pkg::POOL_CAPACITY);

	// per-pool counters
	logic [CW-1:0] point_used_q, named_used_q, point_top_q, named_top_q;

	// latched request
	logic [1:0]                        cmd_q;
	logic                              pool_q;
	logic [tpha_pkg::FIELD_SLOT_W-1:0] slot_q;

	// RAM ports
	logic          live_we, live_wdata, live_rdata;
	logic [AW-1:0] live_waddr, live_raddr;
	logic          stk_we;
	logic [AW-1:0] stk_waddr, stk_raddr;
	logic [SW-1:0] stk_wdata, stk_rdata;

	logic [CW-1:0] req_top, cur_used, cur_top, new_used, new_top;
	logic [SW-1:0] id;
	logic          clr;
	tpha_pkg::rsp_t res;

	// read side, issued on the accept edge
	assign req_top    = req.pool ? named_top_q : point_top_q;
	assign stk_raddr  = {req.pool, SW'(req_top - CW'(1))};
	assign live_raddr = {req.pool, SW'(req.slot)};

	tpha_ram #(.WIDTH(1), .DEPTH(tpha_pkg::MEM_DEPTH)) u_live (
		.clk  (clk),
		.we   (live_we),
		.waddr(live_waddr),
		.wdata(live_wdata),
		.re   (cmd.load),
		.raddr(live_raddr),
		.rdata(live_rdata)
	);

	tpha_ram #(.WIDTH(SW), .DEPTH(tpha_pkg::MEM_DEPTH)) u_stack (
		.clk  (clk),
		.we   (stk_we),
		.waddr(stk_waddr),
		.wdata(stk_wdata),
		.re   (cmd.load),
		.raddr(stk_raddr),
		.rdata(stk_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q  <= req.cmd;
			pool_q <= req.pool;
			slot_q <= req.slot;
		end
		if (cmd.exec && sts.known) begin
			rsp <= res;
		end
	end

	assign cur_used = pool_q ? named_used_q : point_used_q;
	assign cur_top  = pool_q ? named_top_q : point_top_q;

	always_comb begin
		new_used     = cur_used;
		new_top      = cur_top;
		clr          = 1'b0;
		sts.known    = 1'b1;
		id           = '0;
		live_we      = 1'b0;
		live_wdata   = 1'b0;
		live_waddr   = {pool_q, SW'(slot_q)};
		stk_we       = 1'b0;
		stk_waddr    = {pool_q, SW'(cur_top)};
		stk_wdata    = SW'(slot_q);
		res.out_pool = pool_q;
		res.out_slot = slot_q;
		res.status   = tpha_pkg::STS_OK;
		case (cmd_q)
			tpha_pkg::CMD_ADD: begin
				if (cur_top != '0) begin
					// reuse the newest freed slot
					id      = stk_rdata;
					new_top = cur_top - CW'(1);
					live_we = cmd.exec;
				end else if (cur_used < CAP) begin
					id       = SW'(cur_used);
					new_used = cur_used + CW'(1);
					live_we  = cmd.exec;
				end else begin
					res.status = tpha_pkg::STS_FULL;
				end
				live_wdata   = 1'b1;
				live_waddr   = {pool_q, id};
				res.out_slot = tpha_pkg::FIELD_SLOT_W'(id);
			end
			tpha_pkg::CMD_REMOVE: begin
				if (CW'(slot_q) >= cur_used) begin
					res.status = tpha_pkg::STS_INVALID;
				end else if (!live_rdata) begin
					res.status = tpha_pkg::STS_REMOVED;
				end else begin
					live_we = cmd.exec;
					if (cur_top < CAP) begin
						stk_we  = cmd.exec;
						new_top = cur_top + CW'(1);
					end
				end
			end
			tpha_pkg::CMD_CLEAR: begin
				clr          = 1'b1;
				res.out_pool = 1'b0;
				res.out_slot = '0;
			end
			default: begin
				sts.known = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_used_q <= '0;
			named_used_q <= '0;
			point_top_q  <= '0;
			named_top_q  <= '0;
		end else if (cmd.exec) begin
			if (clr) begin
				point_used_q <= '0;
				named_used_q <= '0;
				point_top_q  <= '0;
				named_top_q  <= '0;
			end else if (pool_q) begin
				named_used_q <= new_used;
				named_top_q  <= new_top;
			end else begin
				point_used_q <= new_used;
				point_top_q  <= new_top;
			end
		end
	end

endmodule

[sv/two_pool_handle_allocator_unit.sv]
// Top level of the two-pool slot handle allocator.
//
// Hands out slot handles (pool, slot) from two independent pools of 256
// slots. An add pops the most recently freed slot of the pool, or else
// appends the next never-used slot, or reports the pool full. A remove
// checks the slot against the pool's high-water count and its live flag,
// then frees it onto the pool's free stack. A clear empties both pools.
// Every command but the unknown code 3 yields exactly one result beat.
// The accept edge (start high, busy low) launches the registered reads of
// the live-flag RAM and the free-stack RAM; busy is then high for one
// cycle while the update is computed and written back. The result beat
// shows on rsp with done high in the cycle after that, and a new start is
// taken in that same cycle; no new start is taken while busy is high. The
// receiver has no way to stall: a result beat is there for one cycle only
// and must be captured then. The RAM contents need no clearing pass after
// reset; the counters reset to zero.
`include "assert_macros.svh"

module two_pool_handle_allocator_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  tpha_pkg::req_t   req,
	output logic             done,
	output tpha_pkg::rsp_t   rsp
);

	tpha_pkg::ctrl_cmd_t ctrl_cmd;
	tpha_pkg::dp_sts_t   dp_sts;

	// sequencing: idle / execute, plus the result strobe
	tpha_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.sts   (dp_sts),
		.cmd   (ctrl_cmd),
		.busy  (busy),
		.done  (done)
	);

	// counters, RAMs and result register
	tpha_dpath u_dpath (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (ctrl_cmd),
		.req   (req),
		.sts   (dp_sts),
		.rsp   (rsp)
	);

	// an accepted beat always occupies the execute cycle
	`ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not enter execute")
	// a result beat only follows an execute cycle
	`ASSERT_IMPLIES(a_done_after_exec, done, $past(busy), "result beat without execute cycle")
	// a full pool reports slot zero
	`ASSERT_IMPLIES(a_full_slot_zero, done && (rsp.status == tpha_pkg::STS_FULL),
		rsp.out_slot == '0, "pool full result with nonzero slot")

endmodule
